// ----- rtl/btid_pkg.sv -----
// ----------------------------------------------------------------------------
// btid_pkg: shared types and constants of the blob track id assigner
// Table entry layout, store control group and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package btid_pkg;

    // Pi in Q2.14, rounded to nearest.
    localparam logic [15:0] PI_Q14 = 16'd51472;

    // Reset value of the minimum match radius.
    localparam logic [7:0] MIN_RADIUS_RESET = 8'd55;

    // Smallest stored size that takes part in matching is one above this.
    localparam logic [15:0] SIZE_FLOOR = 16'd1;

    // One stored blob.
    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [15:0] size;
        logic [15:0] id;
    } entry_t;

    // Control group from the sequencer to the table store.
    typedef struct packed {
        logic rd_en;   // read one entry of a search table
        logic rd_old;  // 1: table from two frames back, 0: last frame
        logic wr_en;   // write the current blob into the building table
        logic rotate;  // frame closes: rotate table roles
    } store_ctrl_t;

endpackage

// ----- rtl/btid_radius.sv -----
// ----------------------------------------------------------------------------
// btid_radius: iterative match radius search
// Finds the largest r in 0..255 with r*r*pi <= size by a binary search, one
// result bit per square phase and compare phase, using two multipliers.
// ----------------------------------------------------------------------------
module btid_radius
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] size,
    output logic        done,
    output logic [7:0]  root
);

    logic        busy_reg;
    logic        phase_reg;
    logic [2:0]  bit_reg;
    logic [7:0]  root_reg;
    logic [7:0]  trial_reg;
    logic [15:0] sq_reg;
    logic [15:0] size_reg;
    logic        done_reg;
    logic [7:0]  trial;
    logic [31:0] prod;
    logic [31:0] scaled;

    // Candidate with the bit under test set, and the scaled bound.
    assign trial  = root_reg | (8'h80 >> bit_reg);
    assign prod   = {16'd0, sq_reg} * {16'd0, btid_pkg::PI_Q14};
    assign scaled = {2'b00, size_reg, 14'd0};

    // Sequencer: phase 0 squares the candidate, phase 1 scales and compares.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            bit_reg   <= 3'd0;
            root_reg  <= 8'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                bit_reg   <= 3'd0;
                root_reg  <= 8'd0;
            end
            else if (busy_reg)
            begin
                phase_reg <= ~phase_reg;
                if (phase_reg)
                begin
                    if (prod <= scaled)
                    begin
                        root_reg <= trial_reg;
                    end
                    if (bit_reg == 3'd7)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        bit_reg <= bit_reg + 3'd1;
                    end
                end
            end
        end
    end

    // Datapath registers between the two multiplications.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            size_reg <= size;
        end
        if (busy_reg && !phase_reg)
        begin
            trial_reg <= trial;
            sq_reg    <= {8'd0, trial} * {8'd0, trial};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/btid_store.sv -----
// ----------------------------------------------------------------------------
// btid_store: three rotating blob tables
// Three banks take the roles building, last frame and two frames back; a
// frame close rotates the roles and clears the new building bank's valid bits.
// ----------------------------------------------------------------------------
module btid_store
#(
    parameter int unsigned ENTRIES = 32,
    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  btid_pkg::store_ctrl_t  ctrl,
    input  logic [IDX_W-1:0]       rd_addr,
    input  logic [IDX_W-1:0]       wr_addr,
    input  btid_pkg::entry_t       wr_data,
    output logic                   rd_vld,
    output logic                   rd_ok,
    output btid_pkg::entry_t       rd_data
);

    localparam int unsigned BANKS = 3;

    logic [1:0]         bld_reg;
    logic [1:0]         rec_reg;
    logic [1:0]         old_reg;
    logic [1:0]         rd_bank;
    logic [1:0]         rd_bank_reg;
    logic               rd_vld_reg;
    logic               rd_ok_reg;
    logic [ENTRIES-1:0] vld_reg [BANKS];
    btid_pkg::entry_t   q_reg [BANKS];

    assign rd_bank = ctrl.rd_old ? old_reg : rec_reg;

    // Role pointers rotate at every frame close.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bld_reg <= 2'd0;
            rec_reg <= 2'd1;
            old_reg <= 2'd2;
        end
        else if (ctrl.rotate)
        begin
            old_reg <= rec_reg;
            rec_reg <= bld_reg;
            bld_reg <= old_reg;
        end
    end

    // One memory bank and its valid bits per role.
    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        btid_pkg::entry_t mem [ENTRIES];

        always_ff @(posedge clk)
        begin
            if (ctrl.wr_en && bld_reg == 2'(b))
            begin
                mem[wr_addr] <= wr_data;
            end
            if (ctrl.rd_en && rd_bank == 2'(b))
            begin
                q_reg[b] <= mem[rd_addr];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[b] <= '0;
            end
            else if (ctrl.rotate && old_reg == 2'(b))
            begin
                vld_reg[b] <= '0;
            end
            else if (ctrl.wr_en && bld_reg == 2'(b))
            begin
                vld_reg[b][wr_addr] <= 1'b1;
            end
        end
    end

    // Read strobe, entry valid flag and bank select are registered alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            rd_ok_reg   <= 1'b0;
            rd_bank_reg <= 2'd0;
        end
        else
        begin
            rd_vld_reg <= ctrl.rd_en;
            if (ctrl.rd_en)
            begin
                rd_ok_reg   <= vld_reg[rd_bank][rd_addr];
                rd_bank_reg <= rd_bank;
            end
        end
    end

    assign rd_vld  = rd_vld_reg;
    assign rd_ok   = rd_ok_reg;
    assign rd_data = q_reg[rd_bank_reg];

    // The three roles always name three different banks.
    assert property (@(posedge clk) disable iff (!rst_n)
        (bld_reg != rec_reg) && (rec_reg != old_reg) && (bld_reg != old_reg))
        else $error("btid_store: table roles overlap");

    // A search read never coincides with a table write or a rotation.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.rd_en |-> !ctrl.wr_en && !ctrl.rotate)
        else $error("btid_store: read during write or rotation");

    // After a rotation the fresh building bank holds no valid entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.rotate |=> (vld_reg[bld_reg] == '0))
        else $error("btid_store: building bank not cleared");

endmodule

// ----- rtl/blob_track_id_assigner_core.sv -----
// ----------------------------------------------------------------------------
// blob_track_id_assigner_core: blob track id assigner
// Gives each detected blob a track id by matching it against the blobs of
// the last frame and, when the blob count fell, of the frame before.
// ----------------------------------------------------------------------------
//  channel   signals                                      direction
//  input     in_valid, in_ready, blobs_in_frame, blob_x,  in
//            blob_y, blob_size
//  output    out_valid, out_ready, track_id, out_x,       out
//            out_y, frame_end
//  config    min_radius_we, min_radius_wdata              in
//
// A blob item runs the radius search, then per table searched one table read
// per entry from a single bank port and a check of the last entry, then
// hands off the result to the output register and returns to take the next
// item.
// An item with a blob count of zero closes the frame as it is accepted.
// Reset clears all tables (valid bits), counters and next id at once.
// The next item is taken while the last result waits on out_ready; a new
// result waits in its final state until the output register is free.
// ----------------------------------------------------------------------------
module blob_track_id_assigner_core
#(
    parameter int unsigned TABLE_ENTRIES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        min_radius_we,
    input  logic [7:0]  min_radius_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  blobs_in_frame,
    input  logic [9:0]  blob_x,
    input  logic [9:0]  blob_y,
    input  logic [15:0] blob_size,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] track_id,
    output logic [9:0]  out_x,
    output logic [9:0]  out_y,
    output logic        frame_end
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_ROOT     = 5'b00010,
        S_SCAN_OLD = 5'b00100,
        S_SCAN_REC = 5'b01000,
        S_DONE     = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [7:0]            min_radius_reg;
    logic [7:0]            cnt_reg;
    logic [9:0]            x_reg;
    logic [9:0]            y_reg;
    logic [15:0]           size_reg;
    logic [7:0]            prev_cnt_reg;
    logic [7:0]            items_reg;
    logic [15:0]           next_id_reg;
    logic [7:0]            rad_reg;
    logic [15:0]           id_reg;
    logic                  found_reg;
    logic [CNT_W-1:0]      scan_cnt_reg;
    logic                  out_valid_reg;
    logic [15:0]           track_id_reg;
    logic [9:0]            out_x_reg;
    logic [9:0]            out_y_reg;
    logic                  frame_end_reg;

    logic                  accept;
    logic                  empty_frame;
    logic                  scan_active;
    logic                  scan_end;
    logic                  commit;
    logic [7:0]            items_inc;
    logic                  frame_done;
    logic [15:0]           final_id;
    logic                  root_done;
    logic [7:0]            root;
    logic                  rd_vld;
    logic                  rd_ok;
    btid_pkg::entry_t      rd_data;
    btid_pkg::entry_t      wr_data;
    btid_pkg::store_ctrl_t store_ctrl;
    logic [9:0]            dx;
    logic [9:0]            dy;
    logic                  hit;
    logic                  take;

    // Handshake and frame bookkeeping.
    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign empty_frame = accept && (blobs_in_frame == 8'd0);
    assign scan_active = (state_reg == S_SCAN_OLD) || (state_reg == S_SCAN_REC);
    assign scan_end    = scan_active && (scan_cnt_reg == CNT_W'(TABLE_ENTRIES));
    assign commit      = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign items_inc   = items_reg + 8'd1;
    assign frame_done  = (items_inc >= cnt_reg);
    assign final_id    = (id_reg != 16'd0) ? id_reg : next_id_reg;

    // Match test on the entry read in the previous cycle.
    assign dx   = (x_reg > rd_data.x) ? (x_reg - rd_data.x) : (rd_data.x - x_reg);
    assign dy   = (y_reg > rd_data.y) ? (y_reg - rd_data.y) : (rd_data.y - y_reg);
    assign hit  = rd_vld && rd_ok && (rd_data.size > btid_pkg::SIZE_FLOOR) &&
                  (dx < {2'b00, rad_reg}) && (dy < {2'b00, rad_reg});
    assign take = hit && !found_reg;

    // Table store control.
    assign store_ctrl.rd_en  = scan_active &&
                               (scan_cnt_reg < CNT_W'(TABLE_ENTRIES));
    assign store_ctrl.rd_old = (state_reg == S_SCAN_OLD);
    assign store_ctrl.wr_en  = commit &&
                               ({1'b0, items_reg} < 9'(TABLE_ENTRIES));
    assign store_ctrl.rotate = empty_frame || (commit && frame_done);

    assign wr_data.x    = x_reg;
    assign wr_data.y    = y_reg;
    assign wr_data.size = size_reg;
    assign wr_data.id   = final_id;

    btid_radius u_radius
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && (blobs_in_frame != 8'd0)),
        .size  (blob_size),
        .done  (root_done),
        .root  (root)
    );

    btid_store #(.ENTRIES(TABLE_ENTRIES)) u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (store_ctrl),
        .rd_addr (scan_cnt_reg[IDX_W-1:0]),
        .wr_addr (items_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_vld  (rd_vld),
        .rd_ok   (rd_ok),
        .rd_data (rd_data)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (blobs_in_frame != 8'd0))
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (root_done)
                begin
                    state_next = (cnt_reg < prev_cnt_reg) ? S_SCAN_OLD : S_SCAN_REC;
                end
            end
            S_SCAN_OLD:
            begin
                if (scan_end)
                begin
                    state_next = S_SCAN_REC;
                end
            end
            S_SCAN_REC:
            begin
                if (scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state: sequencer, counters, frame history and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            min_radius_reg <= btid_pkg::MIN_RADIUS_RESET;
            prev_cnt_reg   <= 8'd0;
            items_reg      <= 8'd0;
            next_id_reg    <= 16'd0;
            found_reg      <= 1'b0;
            scan_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (min_radius_we)
            begin
                min_radius_reg <= min_radius_wdata;
            end

            // Table search bookkeeping.
            if (state_reg == S_ROOT)
            begin
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
            end
            else if (scan_end)
            begin
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (store_ctrl.rd_en)
                begin
                    scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end

            // Frame close on an empty-frame item.
            if (empty_frame)
            begin
                prev_cnt_reg <= 8'd0;
                items_reg    <= 8'd0;
            end

            // Result handoff and frame bookkeeping.
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                if (id_reg == 16'd0)
                begin
                    next_id_reg <= next_id_reg + 16'd1;
                end
                if (frame_done)
                begin
                    prev_cnt_reg <= cnt_reg;
                    items_reg    <= 8'd0;
                end
                else
                begin
                    items_reg <= items_inc;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cnt_reg  <= blobs_in_frame;
            x_reg    <= blob_x;
            y_reg    <= blob_y;
            size_reg <= blob_size;
        end
        if (root_done)
        begin
            rad_reg <= (root < min_radius_reg) ? min_radius_reg : root;
            id_reg  <= 16'd0;
        end
        else if (take)
        begin
            id_reg <= rd_data.id;
        end
        if (commit)
        begin
            track_id_reg  <= final_id;
            out_x_reg     <= x_reg;
            out_y_reg     <= y_reg;
            frame_end_reg <= frame_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign track_id  = track_id_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign frame_end = frame_end_reg;

endmodule
